FILE: hw/rtl/lbpg_pkg.sv
// Package for the LED blink pattern generator.
// Holds the stored request type, the sequencer state codes and the fixed constants.
// No dependencies; used by led_blink_pattern_generator_top.
package lbpg_pkg;

  // One stored light request.
  typedef struct packed {
    logic [23:0] color;
    logic [1:0]  mode;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } req_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_REDUCE = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_e;

  // Flash mode codes.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_TIMED = 2'd1;

  // Source codes.
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_NOTIFY = 2'd1;
  localparam logic [1:0] SRC_BATT   = 2'd2;

  // Blink limits in ms.
  localparam int unsigned MaxTotalMs = 15000;
  localparam int unsigned MaxOnMs    = 8000;

  // Slot lengths in quarter ms for the 1 s and 8 s windows (window / 32 slots).
  localparam int unsigned StepShortQ = 125;
  localparam int unsigned StepLongQ  = 1000;

  // Window length in quarter ms, four times its value in ms.
  localparam int unsigned Win4Short = 4000;
  localparam int unsigned Win4Long  = 32000;

  // Highest shift used when reducing the slot residue by multiples of the period.
  localparam int unsigned ReduceTop = 6;

  localparam int unsigned NumSlots = 32;

  // Cleared pattern values.
  localparam logic [3:0] WIN_SHORT   = 4'd1;
  localparam logic [3:0] WIN_LONG    = 4'd8;
  localparam logic [8:0] DIM_CLEARED = 9'd500;

endpackage

FILE: hw/rtl/led_blink_pattern_generator_top.sv
// LED blink pattern generator, top level.
// Depends on lbpg_pkg for the request type, state codes and constants.
//
// Each input item updates the stored request of the notification or the battery
// source and yields one result item: the request that is shown (notification if
// lit, else battery, else none), its RGB levels, and for a timed blink a 32-slot
// on/off bitmap over a 1 s or 8 s window with the dim ramp time and the
// whole-second delay. The block takes one item at a time. An item that needs no
// bitmap passes from the accepting idle state through the prep and finish states
// to the output register. A timed blink walks the 32 slots with one shared
// subtractor: each slot gets one check state, and every slot but the last then
// adds the slot length and reduces the residue modulo the period with one
// compare-and-subtract per shift, from the highest shift down to zero. A stalled
// result side holds the block in its finish state. The result sits in an output
// register, so a new item can be accepted while the previous result still waits
// to be taken. After reset both requests are unlit.
module led_blink_pattern_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [23:0] color_i,
  input  logic [1:0]  flash_mode_i,
  input  logic [15:0] on_ms_i,
  input  logic [15:0] off_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  source_o,
  output logic [31:0] pattern_bits_o,
  output logic        soft_dim_o,
  output logic [3:0]  window_secs_o,
  output logic [2:0]  delay_secs_o,
  output logic [8:0]  dim_ms_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  localparam int unsigned DivW = 17 + lbpg_pkg::ReduceTop;

  lbpg_pkg::state_e state_q, state_d;
  lbpg_pkg::req_t   req_q [2];

  logic [13:0] on_q, p_q;
  logic        long_q;
  logic [14:0] t_q;
  logic [16:0] s_q;
  logic [2:0]  k_q;
  logic [4:0]  n_q;
  logic [31:0] bits_q;

  logic        out_valid_q;
  logic [1:0]  source_q;
  logic [31:0] pattern_q;
  logic        use_q;
  logic [3:0]  win_q;
  logic [2:0]  delay_q;
  logic [8:0]  dim_q;
  logic [7:0]  red_q, green_q, blue_q;

  logic in_fire;
  assign in_ready_o = (state_q == lbpg_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Selection of the shown request and everything that does not need the bitmap.
  lbpg_pkg::req_t sel;
  logic        lit;
  logic [1:0]  src_c;
  logic        use_c, run_c, long_c;
  logic [16:0] sum_raw;
  logic [13:0] on_c, off_c, p_c, lim_off, min_c;
  logic [15:0] on3;
  logic [3:0]  win_c;
  logic [2:0]  delay_c;
  logic [8:0]  dim_c;

  always_comb begin
    sel = req_q[0];
    src_c = lbpg_pkg::SRC_NOTIFY;
    lit = 1'b1;
    if (req_q[0].color == '0) begin
      sel = req_q[1];
      src_c = lbpg_pkg::SRC_BATT;
      if (req_q[1].color == '0) begin
        src_c = lbpg_pkg::SRC_NONE;
        lit = 1'b0;
      end
    end

    use_c = lit && (sel.mode == lbpg_pkg::MODE_TIMED) && (sel.off_ms != '0);
    run_c = use_c && (sel.on_ms != '0);

    // Clip the blink to the on and total limits.
    sum_raw = {1'b0, sel.on_ms} + {1'b0, sel.off_ms};
    on_c  = sel.on_ms[13:0];
    off_c = sel.off_ms[13:0];
    if (sum_raw > 17'(lbpg_pkg::MaxTotalMs)) begin
      on_c = (sel.on_ms > 16'(lbpg_pkg::MaxOnMs)) ? 14'(lbpg_pkg::MaxOnMs) : sel.on_ms[13:0];
      lim_off = 14'(lbpg_pkg::MaxTotalMs) - on_c;
      off_c = (sel.off_ms > {2'b00, lim_off}) ? lim_off : sel.off_ms[13:0];
    end else begin
      lim_off = '0;
    end
    p_c    = on_c + off_c;
    long_c = !((p_c < 14'd8000) && (on_c < 14'd1000));
    min_c  = (off_c > on_c) ? on_c : off_c;
    on3    = {2'b00, on_c} + {1'b0, on_c, 1'b0};

    // Defaults are the cleared values.
    win_c   = lbpg_pkg::WIN_SHORT;
    delay_c = 3'd1;
    dim_c   = lbpg_pkg::DIM_CLEARED;
    if (use_c) begin
      win_c   = lbpg_pkg::WIN_SHORT;
      delay_c = 3'd0;
      dim_c   = 9'd50;
      if (run_c) begin
        if (min_c > 14'd500) dim_c = 9'd500;
        else if (min_c > 14'd190) dim_c = 9'd190;
        else if (min_c > 14'd95) dim_c = 9'd95;
        else dim_c = 9'd50;
        if (long_c) begin
          // The clipped total stays below 16 s, so a long blink has no delay.
          win_c = lbpg_pkg::WIN_LONG;
        end else if (p_c < 14'd2000) begin
          delay_c = ({2'b00, off_c} > on3) ? 3'd1 : 3'd0;
        end else begin
          // Whole seconds of total beyond the first, for totals of 2 s to 8 s.
          delay_c = 3'(32'(p_c >= 14'd2000) + 32'(p_c >= 14'd3000) + 32'(p_c >= 14'd4000)
                      + 32'(p_c >= 14'd5000) + 32'(p_c >= 14'd6000)
                      + 32'(p_c >= 14'd7000));
        end
      end
    end
  end

  // Slot evaluation datapath. s_q holds the slot time plus three quarter ms,
  // taken modulo the period; t_q is the slot start in quarter ms.
  logic [DivW-1:0] div_sh;
  logic            sub_ok;
  logic [16:0]     lim_on, t3, p4, base;
  logic [17:0]     base_p;
  logic            slot_bit;
  logic [9:0]      step_c;

  always_comb begin
    div_sh = DivW'({p_q, 2'b00}) << k_q;
    sub_ok = {{(DivW-17){1'b0}}, s_q} >= div_sh;

    lim_on = {1'b0, on_q, 2'b00} + 17'd3;
    t3     = {2'b00, t_q} + 17'd3;
    p4     = {1'b0, p_q, 2'b00};
    base   = t3 - s_q;
    base_p = {1'b0, base} + {3'b000, p_q, 1'b0};
    // Inside the on time of its period, and that period is one of the rounded count.
    slot_bit = (s_q < lim_on) && ((t3 < p4) ||
               (base_p <= (long_q ? 18'(lbpg_pkg::Win4Long) : 18'(lbpg_pkg::Win4Short))));
    step_c = long_q ? 10'(lbpg_pkg::StepLongQ) : 10'(lbpg_pkg::StepShortQ);
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbpg_pkg::ST_IDLE:   if (in_fire) state_d = lbpg_pkg::ST_PREP;
      lbpg_pkg::ST_PREP:   state_d = run_c ? lbpg_pkg::ST_CHECK : lbpg_pkg::ST_FINISH;
      lbpg_pkg::ST_CHECK:  state_d = (n_q == 5'(lbpg_pkg::NumSlots - 1)) ?
                                     lbpg_pkg::ST_FINISH : lbpg_pkg::ST_REDUCE;
      lbpg_pkg::ST_REDUCE: if (k_q == '0) state_d = lbpg_pkg::ST_CHECK;
      lbpg_pkg::ST_FINISH: if (out_free) state_d = lbpg_pkg::ST_IDLE;
      default:             state_d = lbpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbpg_pkg::ST_IDLE;
      req_q[0] <= '0;
      req_q[1] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        req_q[func_i] <= '{color: color_i, mode: flash_mode_i,
                           on_ms: on_ms_i, off_ms: off_ms_i};
      end
      if (state_q == lbpg_pkg::ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result registers carry payload only.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lbpg_pkg::ST_PREP: begin
        on_q   <= on_c;
        p_q    <= p_c;
        long_q <= long_c;
        t_q    <= '0;
        s_q    <= 17'd3;
        n_q    <= '0;
        k_q    <= 3'(lbpg_pkg::ReduceTop);
        bits_q <= '0;
      end
      lbpg_pkg::ST_CHECK: begin
        bits_q <= {slot_bit, bits_q[31:1]};
        n_q    <= n_q + 5'd1;
        t_q    <= t_q + {5'b00000, step_c};
        s_q    <= s_q + {7'b0000000, step_c};
        k_q    <= 3'(lbpg_pkg::ReduceTop);
      end
      lbpg_pkg::ST_REDUCE: begin
        if (sub_ok) s_q <= s_q - div_sh[16:0];
        k_q <= k_q - 3'd1;
      end
      lbpg_pkg::ST_FINISH: begin
        if (out_free) begin
          source_q  <= src_c;
          pattern_q <= bits_q;
          use_q     <= use_c;
          win_q     <= win_c;
          delay_q   <= delay_c;
          dim_q     <= dim_c;
          red_q     <= lit ? sel.color[23:16] : 8'd0;
          green_q   <= lit ? sel.color[15:8] : 8'd0;
          blue_q    <= lit ? sel.color[7:0] : 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign source_o       = source_q;
  assign pattern_bits_o = pattern_q;
  assign soft_dim_o     = use_q;
  assign window_secs_o  = win_q;
  assign delay_secs_o   = delay_q;
  assign dim_ms_o       = dim_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;

  // A result without the pattern carries the cleared pattern fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !soft_dim_o |-> pattern_bits_o == '0 &&
      window_secs_o == lbpg_pkg::WIN_SHORT && delay_secs_o == 3'd1 &&
      dim_ms_o == lbpg_pkg::DIM_CLEARED)
    else $error("cleared pattern fields wrong");

  // Nothing shown means dark LEDs and no pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && source_o == lbpg_pkg::SRC_NONE |->
      red_o == '0 && green_o == '0 && blue_o == '0 && !soft_dim_o)
    else $error("unlit result not dark");

  // A long window never has a delay.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_secs_o == lbpg_pkg::WIN_LONG |-> delay_secs_o == 3'd0)
    else $error("long window with delay");

  // Once the smallest shift is done, the reduction hands back to the slot check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lbpg_pkg::ST_REDUCE && k_q == '0 |=> state_q == lbpg_pkg::ST_CHECK)
    else $error("reduce did not return to check");

endmodule

FILE: tb/lbpg_checker.sv
`timescale 1ns / 100ps
// Result checker for the LED blink pattern generator: watches both channels, predicts each
// result item from its own copy of the two stored requests and compares field by field.
// Depends on lbpg_pkg for the request type, the code constants and the blink limits.
module lbpg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [23:0] color_i,
  input  logic [1:0]  flash_mode_i,
  input  logic [15:0] on_ms_i,
  input  logic [15:0] off_ms_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  source_i,
  input  logic [31:0] pattern_bits_i,
  input  logic        soft_dim_i,
  input  logic [3:0]  window_secs_i,
  input  logic [2:0]  delay_secs_i,
  input  logic [8:0]  dim_ms_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam longint ShortWindowMs = 1000;
  localparam longint LongWindowMs  = 8000;

  typedef struct packed {
    logic [1:0]  source;
    logic [31:0] pattern_bits;
    logic        soft_dim;
    logic [3:0]  window_secs;
    logic [2:0]  delay_secs;
    logic [8:0]  dim_ms;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } light_t;

  lbpg_pkg::req_t held_req [2];
  light_t         light_q[$];

  function automatic logic [8:0] ramp_ms(longint shorter_ms);
    if (shorter_ms > 500) return 9'd500;
    if (shorter_ms > 190) return 9'd190;
    if (shorter_ms > 95) return 9'd95;
    return 9'd50;
  endfunction

  // Slot n starts at n * window / 32 ms, held in quarter ms. A slot is lit when its
  // truncated start time falls inside the on part of any period in the window.
  function automatic logic [31:0] slot_bitmap(longint window_ms, longint on_t, longint off_t);
    longint      period;
    longint      periods;
    longint      step_q;
    longint      q;
    logic [31:0] bits;
    period  = on_t + off_t;
    periods = (2 * window_ms + period) / (2 * period);
    step_q  = window_ms / 8;
    bits    = '0;
    if (periods == 0) periods = 1;
    for (int slot = 0; slot < lbpg_pkg::NumSlots; slot++) begin
      for (longint c = 0; c < periods; c++) begin
        q = step_q * slot - 4 * c * period;
        if (q >= -3 && q < 4 * on_t) bits[slot] = 1'b1;
      end
    end
    return bits;
  endfunction

  function automatic light_t predict_light(lbpg_pkg::req_t notify, lbpg_pkg::req_t batt);
    light_t         res;
    lbpg_pkg::req_t shown;
    longint         on_t;
    longint         off_t;
    longint         total;
    res = '{source: lbpg_pkg::SRC_NONE, pattern_bits: '0, soft_dim: 1'b0,
            window_secs: lbpg_pkg::WIN_SHORT, delay_secs: 3'd1,
            dim_ms: lbpg_pkg::DIM_CLEARED, red: '0, green: '0, blue: '0};
    if (notify.color != '0) begin
      shown = notify;
      res.source = lbpg_pkg::SRC_NOTIFY;
    end else if (batt.color != '0) begin
      shown = batt;
      res.source = lbpg_pkg::SRC_BATT;
    end else begin
      return res;
    end
    res.red   = shown.color[23:16];
    res.green = shown.color[15:8];
    res.blue  = shown.color[7:0];
    if (shown.mode != lbpg_pkg::MODE_TIMED || shown.off_ms == '0) return res;
    res.soft_dim   = 1'b1;
    res.delay_secs = 3'd0;
    res.dim_ms     = 9'd50;
    if (shown.on_ms == '0) return res;
    on_t  = longint'(shown.on_ms);
    off_t = longint'(shown.off_ms);
    if (on_t + off_t > longint'(lbpg_pkg::MaxTotalMs)) begin
      if (on_t > longint'(lbpg_pkg::MaxOnMs)) on_t = longint'(lbpg_pkg::MaxOnMs);
      if (off_t > longint'(lbpg_pkg::MaxTotalMs) - on_t) begin
        off_t = longint'(lbpg_pkg::MaxTotalMs) - on_t;
      end
    end
    total = on_t + off_t;
    res.dim_ms = ramp_ms(off_t > on_t ? on_t : off_t);
    if (total < LongWindowMs && on_t < ShortWindowMs) begin
      res.pattern_bits = slot_bitmap(ShortWindowMs, on_t, off_t);
      if (total < 2000) res.delay_secs = (off_t > 3 * on_t) ? 3'd1 : 3'd0;
      else res.delay_secs = 3'((total - 1000) / 1000);
    end else begin
      // The clipped total stays below 16 s, so a long window never adds a delay.
      res.window_secs  = lbpg_pkg::WIN_LONG;
      res.pattern_bits = slot_bitmap(LongWindowMs, on_t, off_t);
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    light_t want;
    if (!rst_ni) begin
      held_req[0]  = '0;
      held_req[1]  = '0;
      light_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (light_q.size() == 0) begin
          $error("result item with no request outstanding");
          fail_count_o++;
        end else begin
          want = light_q.pop_front();
          check_field("source", 32'(want.source), 32'(source_i));
          check_field("pattern_bits", want.pattern_bits, pattern_bits_i);
          check_field("soft_dim", 32'(want.soft_dim), 32'(soft_dim_i));
          check_field("window_secs", 32'(want.window_secs), 32'(window_secs_i));
          check_field("delay_secs", 32'(want.delay_secs), 32'(delay_secs_i));
          check_field("dim_ms", 32'(want.dim_ms), 32'(dim_ms_i));
          check_field("red", 32'(want.red), 32'(red_i));
          check_field("green", 32'(want.green), 32'(green_i));
          check_field("blue", 32'(want.blue), 32'(blue_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        held_req[func_i] = '{color: color_i, mode: flash_mode_i, on_ms: on_ms_i,
                             off_ms: off_ms_i};
        light_q.push_back(predict_light(held_req[0], held_req[1]));
      end
    end
    pending_o = light_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the LED blink pattern generator testbench: clock, reset, request stimulus and verdict.
// Depends on lbpg_pkg, led_blink_pattern_generator_top and lbpg_checker.
module tb_top;

  // Flash modes without a name in the package; both behave like no flashing.
  localparam logic [1:0] ModeHardware = 2'd2;
  localparam logic [1:0] ModeSpare    = 2'd3;

  // The limit leaves ample room above the slowest correct run of about 1375 items,
  // with the longest input gap and the longest output stall on every item.
  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned RandomItems = 1350;
  // Cycles to watch after the last result so that a stray extra result is caught.
  localparam int unsigned DrainCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [23:0] color_i;
  logic [1:0]  flash_mode_i;
  logic [15:0] on_ms_i;
  logic [15:0] off_ms_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  source_o;
  logic [31:0] pattern_bits_o;
  logic        soft_dim_o;
  logic [3:0]  window_secs_o;
  logic [2:0]  delay_secs_o;
  logic [8:0]  dim_ms_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // When set, neither side inserts gaps, so items follow each other back to back.
  bit calm = 1'b0;

  led_blink_pattern_generator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .color_i       (color_i),
    .flash_mode_i  (flash_mode_i),
    .on_ms_i       (on_ms_i),
    .off_ms_i      (off_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .source_o      (source_o),
    .pattern_bits_o(pattern_bits_o),
    .soft_dim_o    (soft_dim_o),
    .window_secs_o (window_secs_o),
    .delay_secs_o  (delay_secs_o),
    .dim_ms_o      (dim_ms_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o)
  );

  lbpg_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .func_i        (func_i),
    .color_i       (color_i),
    .flash_mode_i  (flash_mode_i),
    .on_ms_i       (on_ms_i),
    .off_ms_i      (off_ms_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .source_i      (source_o),
    .pattern_bits_i(pattern_bits_o),
    .soft_dim_i    (soft_dim_o),
    .window_secs_i (window_secs_o),
    .delay_secs_i  (delay_secs_o),
    .dim_ms_i      (dim_ms_o),
    .red_i         (red_o),
    .green_i       (green_o),
    .blue_i        (blue_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one request item. The input gap is drawn per item; valid stays high from one
  // item to the next when the gap is zero, so only one assignment lands per edge.
  task automatic send_item(logic func, logic [23:0] color, logic [1:0] mode,
                           logic [15:0] on_t, logic [15:0] off_t);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    color_i      <= color;
    flash_mode_i <= mode;
    on_ms_i      <= on_t;
    off_ms_i     <= off_t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Blink times spread over the classes that matter: zero, very short periods, the
  // 1 s window, the 8 s window, values that get clipped and fully random words.
  function automatic logic [15:0] blink_ms();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'($urandom_range(1, 20));
      2, 3:    return 16'($urandom_range(1, 999));
      4, 5:    return 16'($urandom_range(1000, 8000));
      6:       return 16'($urandom_range(8001, 65535));
      default: return 16'($urandom());
    endcase
  endfunction

  // Result side: before each result item the receiver holds ready low for a drawn number
  // of cycles, then keeps it high until a result is taken.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [1:0] mode;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = 1'b0;
    color_i      = '0;
    flash_mode_i = lbpg_pkg::MODE_NONE;
    on_ms_i      = '0;
    off_ms_i     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Nothing lit, then a steady battery light and a timed battery blink.
    send_item(1'b0, 24'h000000, lbpg_pkg::MODE_NONE, 16'd0, 16'd0);
    send_item(1'b1, 24'hFFFFFF, lbpg_pkg::MODE_NONE, 16'd0, 16'd0);
    send_item(1'b1, 24'h010203, lbpg_pkg::MODE_TIMED, 16'd500, 16'd500);
    // Notification takes over: zero on time, zero off time, and the two untimed modes.
    send_item(1'b0, 24'hFFFFFF, lbpg_pkg::MODE_TIMED, 16'd0, 16'd100);
    send_item(1'b0, 24'h800000, lbpg_pkg::MODE_TIMED, 16'd100, 16'd0);
    send_item(1'b0, 24'h00FF00, ModeHardware, 16'd300, 16'd700);
    send_item(1'b0, 24'h0000FF, ModeSpare, 16'd300, 16'd700);
    // Clipping of the on time and of the total, from both ends.
    send_item(1'b0, 24'h123456, lbpg_pkg::MODE_TIMED, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 24'hABCDEF, lbpg_pkg::MODE_TIMED, 16'hFFFF, 16'd1);
    send_item(1'b0, 24'h654321, lbpg_pkg::MODE_TIMED, 16'd1, 16'hFFFF);
    send_item(1'b0, 24'h7F7F7F, lbpg_pkg::MODE_TIMED, 16'd8000, 16'd7000);
    // The shortest period, and the edges between the 1 s and the 8 s window.
    send_item(1'b0, 24'h000001, lbpg_pkg::MODE_TIMED, 16'd1, 16'd1);
    send_item(1'b0, 24'h010000, lbpg_pkg::MODE_TIMED, 16'd999, 16'd1);
    send_item(1'b0, 24'h000100, lbpg_pkg::MODE_TIMED, 16'd999, 16'd6999);
    send_item(1'b0, 24'h0F0F0F, lbpg_pkg::MODE_TIMED, 16'd999, 16'd7001);
    send_item(1'b0, 24'hF0F0F0, lbpg_pkg::MODE_TIMED, 16'd1000, 16'd1);
    // Delay rules in the short window: long off part, total just at 2 s.
    send_item(1'b0, 24'h333333, lbpg_pkg::MODE_TIMED, 16'd100, 16'd400);
    send_item(1'b0, 24'h444444, lbpg_pkg::MODE_TIMED, 16'd100, 16'd1900);
    send_item(1'b0, 24'h555555, lbpg_pkg::MODE_TIMED, 16'd300, 16'd300);
    // Dim time steps: one item in each of the four ramp classes.
    send_item(1'b0, 24'h666666, lbpg_pkg::MODE_TIMED, 16'd95, 16'd95);
    send_item(1'b0, 24'h777777, lbpg_pkg::MODE_TIMED, 16'd96, 16'd191);
    send_item(1'b0, 24'h888888, lbpg_pkg::MODE_TIMED, 16'd191, 16'd191);
    send_item(1'b0, 24'h999999, lbpg_pkg::MODE_TIMED, 16'd501, 16'd600);
    // Notification goes dark: battery blink shows again, then nothing at all.
    send_item(1'b0, 24'h000000, lbpg_pkg::MODE_TIMED, 16'd200, 16'd200);
    send_item(1'b1, 24'h000000, lbpg_pkg::MODE_NONE, 16'd0, 16'd0);

    // Random part. Mostly timed blinks, with a quarter of the colours dark so that the
    // shown source moves between notification, battery and none. Every 150 items the
    // idling is either kept random or switched off for the whole stretch.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      mode = ($urandom_range(0, 9) < 7) ? lbpg_pkg::MODE_TIMED : 2'($urandom_range(0, 3));
      send_item(1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 24'h000000 : 24'($urandom()),
                mode, blink_ms(), blink_ms());
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
